@@ hw/rtl/owbm_pkg.sv @@
// ----------------------------------------------------------------------------
// owbm_pkg
// shared types, register indexes and timing constants of the 1-wire master
// ----------------------------------------------------------------------------
package owbm_pkg;

    // configuration register file
    localparam int NUM_CFG   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_RST_LOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRES_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RST_REC   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_W1_LOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_W1_HIGH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_W0_LOW    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_W0_HIGH   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_RD_WAIT   = 3'd7;

    typedef logic [CFG_W-1:0] t_cfg_word;

    localparam t_cfg_word CFG_RESET_VAL [NUM_CFG] = '{
        10'd480, 10'd70, 10'd410, 10'd5, 10'd55, 10'd60, 10'd5, 10'd10
    };

    // fixed read slot timing in microseconds
    localparam t_cfg_word READ_LOW_TIME = 10'd3;
    localparam t_cfg_word READ_REC_TIME = 10'd50;

    localparam int TIMER_BITS_DEF = 10;

    // command codes
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_RESET = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    // front to back queue
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] write_data;
        logic       line_level;
    } t_in_beat;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence_level;
        logic [7:0] read_data;
        logic       rejected;
    } t_out_beat;

    // classified tick as it travels through the queue
    typedef struct packed {
        logic       cmd_start;
        logic [1:0] req;
        logic [7:0] wdata;
        logic       level;
    } t_qent;

    typedef enum logic [8:0] {
        PH_IDLE     = 9'b000000001,
        PH_RST_LOW  = 9'b000000010,
        PH_RST_WAIT = 9'b000000100,
        PH_RST_REC  = 9'b000001000,
        PH_WR_LOW   = 9'b000010000,
        PH_WR_HIGH  = 9'b000100000,
        PH_RD_LOW   = 9'b001000000,
        PH_RD_WAIT  = 9'b010000000,
        PH_RD_REC   = 9'b100000000
    } t_phase;

endpackage

@@ hw/rtl/owbm_front.sv @@
// ----------------------------------------------------------------------------
// owbm_front
// takes input beats, tags command ticks, queues all beats for the bus engine
// ----------------------------------------------------------------------------
module owbm_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  owbm_pkg::t_in_beat i_data,
    output logic              o_q_valid,
    output owbm_pkg::t_qent   o_q_ent,
    input  logic              i_q_pop
);

    localparam int DEPTH = owbm_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    owbm_pkg::t_qent r_mem [DEPTH];
    owbm_pkg::t_qent w_ent;
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_push;
    logic             w_pop;

    // classify the tick
    always_comb begin
        w_ent.cmd_start = (i_data.req_type != owbm_pkg::REQ_TICK);
        w_ent.req       = i_data.req_type;
        w_ent.wdata     = i_data.write_data;
        w_ent.level     = i_data.line_level;
    end

    assign o_stall   = (r_count == CNT_W'(DEPTH));
    assign w_push    = i_valid && !o_stall;
    assign o_q_valid = (r_count != '0);
    assign w_pop     = i_q_pop && o_q_valid;
    assign o_q_ent   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_ent;
        end
    end

endmodule

@@ hw/rtl/owbm_back.sv @@
// ----------------------------------------------------------------------------
// owbm_back
// bus engine: one microsecond tick per queued entry, plus the result register
// ----------------------------------------------------------------------------
module owbm_back #(
    parameter int TIMER_BITS = owbm_pkg::TIMER_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_q_valid,
    input  owbm_pkg::t_qent                 i_q_ent,
    output logic                            o_q_pop,
    input  logic                            i_cfg_we,
    input  logic [owbm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  owbm_pkg::t_cfg_word             i_cfg_data,
    output logic                            o_valid,
    input  logic                            i_stall,
    output owbm_pkg::t_out_beat             o_data
);

    localparam int EXT_W = (TIMER_BITS > owbm_pkg::CFG_W) ? TIMER_BITS : owbm_pkg::CFG_W;
    localparam logic [EXT_W-1:0] TMAX = EXT_W'((64'd1 << TIMER_BITS) - 64'd1);

    owbm_pkg::t_cfg_word r_cfg [owbm_pkg::NUM_CFG];

    owbm_pkg::t_phase        r_phase, n_phase;
    logic [TIMER_BITS-1:0]   r_timer, n_timer;
    logic [2:0]              r_bit, n_bit;
    logic [7:0]              r_shift, n_shift;
    logic                    r_pres, n_pres;
    logic [7:0]              r_rdata, n_rdata;
    logic                    r_out_valid;
    owbm_pkg::t_out_beat     r_out;
    owbm_pkg::t_out_beat     w_res;
    logic                    w_step;

    // zero counts as one, long values clip to the timer range
    function automatic logic [TIMER_BITS-1:0] f_dur(input owbm_pkg::t_cfg_word d);
        logic [EXT_W-1:0] e;
        e = EXT_W'(d);
        if (e == '0) begin
            e = EXT_W'(1);
        end
        if (e > TMAX) begin
            e = TMAX;
        end
        return TIMER_BITS'(e);
    endfunction

    assign w_step  = i_q_valid && (!r_out_valid || !i_stall);
    assign o_q_pop = w_step;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_comb begin
        n_phase = r_phase;
        n_timer = r_timer;
        n_bit   = r_bit;
        n_shift = r_shift;
        n_pres  = r_pres;
        n_rdata = r_rdata;
        w_res   = '0;

        // end of the running phase
        if (r_phase != owbm_pkg::PH_IDLE && r_timer == '0) begin
            case (r_phase)
                owbm_pkg::PH_RST_LOW: begin
                    n_phase = owbm_pkg::PH_RST_WAIT;
                    n_timer = f_dur(r_cfg[owbm_pkg::CFG_PRES_WAIT]);
                end
                owbm_pkg::PH_RST_WAIT: begin
                    n_pres  = i_q_ent.level;
                    n_phase = owbm_pkg::PH_RST_REC;
                    n_timer = f_dur(r_cfg[owbm_pkg::CFG_RST_REC]);
                end
                owbm_pkg::PH_WR_LOW: begin
                    n_phase = owbm_pkg::PH_WR_HIGH;
                    n_timer = r_shift[0] ? f_dur(r_cfg[owbm_pkg::CFG_W1_HIGH])
                                         : f_dur(r_cfg[owbm_pkg::CFG_W0_HIGH]);
                end
                owbm_pkg::PH_WR_HIGH: begin
                    n_shift = {1'b0, r_shift[7:1]};
                    if (r_bit == 3'd7) begin
                        w_res.done_res = 1'b1;
                    end else begin
                        n_bit   = r_bit + 3'd1;
                        n_phase = owbm_pkg::PH_WR_LOW;
                        n_timer = r_shift[1] ? f_dur(r_cfg[owbm_pkg::CFG_W1_LOW])
                                             : f_dur(r_cfg[owbm_pkg::CFG_W0_LOW]);
                    end
                end
                owbm_pkg::PH_RD_LOW: begin
                    n_phase = owbm_pkg::PH_RD_WAIT;
                    n_timer = f_dur(r_cfg[owbm_pkg::CFG_RD_WAIT]);
                end
                owbm_pkg::PH_RD_WAIT: begin
                    if (i_q_ent.level) begin
                        n_shift[r_bit] = 1'b1;
                    end
                    n_phase = owbm_pkg::PH_RD_REC;
                    n_timer = f_dur(owbm_pkg::READ_REC_TIME);
                end
                owbm_pkg::PH_RD_REC: begin
                    if (r_bit == 3'd7) begin
                        n_rdata        = r_shift;
                        w_res.done_res = 1'b1;
                    end else begin
                        n_bit   = r_bit + 3'd1;
                        n_phase = owbm_pkg::PH_RD_LOW;
                        n_timer = f_dur(owbm_pkg::READ_LOW_TIME);
                    end
                end
                default: begin
                    w_res.done_res = 1'b1;
                end
            endcase
            if (w_res.done_res) begin
                n_phase = owbm_pkg::PH_IDLE;
                n_timer = '0;
                n_bit   = '0;
            end
        end

        // new command
        if (i_q_ent.cmd_start) begin
            if (n_phase != owbm_pkg::PH_IDLE) begin
                w_res.rejected = 1'b1;
            end else begin
                n_bit = '0;
                case (i_q_ent.req)
                    owbm_pkg::REQ_RESET: begin
                        n_phase = owbm_pkg::PH_RST_LOW;
                        n_timer = f_dur(r_cfg[owbm_pkg::CFG_RST_LOW]);
                    end
                    owbm_pkg::REQ_WRITE: begin
                        n_shift = i_q_ent.wdata;
                        n_phase = owbm_pkg::PH_WR_LOW;
                        n_timer = i_q_ent.wdata[0] ? f_dur(r_cfg[owbm_pkg::CFG_W1_LOW])
                                                   : f_dur(r_cfg[owbm_pkg::CFG_W0_LOW]);
                    end
                    default: begin
                        n_shift = '0;
                        n_phase = owbm_pkg::PH_RD_LOW;
                        n_timer = f_dur(owbm_pkg::READ_LOW_TIME);
                    end
                endcase
            end
        end

        // drive and count this microsecond
        if (n_phase != owbm_pkg::PH_IDLE) begin
            w_res.drive_low = (n_phase == owbm_pkg::PH_RST_LOW) ||
                              (n_phase == owbm_pkg::PH_WR_LOW)  ||
                              (n_phase == owbm_pkg::PH_RD_LOW);
            if (n_timer != '0) begin
                n_timer = n_timer - TIMER_BITS'(1);
            end
        end

        w_res.busy_res       = (n_phase != owbm_pkg::PH_IDLE);
        w_res.presence_level = n_pres;
        w_res.read_data      = n_rdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < owbm_pkg::NUM_CFG; i++) begin
                r_cfg[i] <= owbm_pkg::CFG_RESET_VAL[i];
            end
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= owbm_pkg::PH_IDLE;
            r_timer     <= '0;
            r_bit       <= '0;
            r_shift     <= '0;
            r_pres      <= 1'b1;
            r_rdata     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_step) begin
                r_phase <= n_phase;
                r_timer <= n_timer;
                r_bit   <= n_bit;
                r_shift <= n_shift;
                r_pres  <= n_pres;
                r_rdata <= n_rdata;
            end
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_res;
        end
    end

`ifndef SYNTHESIS
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == owbm_pkg::PH_IDLE) |-> (r_timer == '0 && r_bit == '0))
        else $error("idle engine holds a live timer or bit count");

    a_phase_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_phase))
        else $error("phase register lost its one-hot code");

    a_drive_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_out.drive_low || r_out.busy_res))
        else $error("line driven low while not busy");

    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.rejected) |-> r_out.busy_res)
        else $error("command rejected while idle");
`endif

endmodule

@@ hw/rtl/one_wire_bus_master.sv @@
// ----------------------------------------------------------------------------
// one_wire_bus_master
// 1-wire bus master stepped one microsecond per input beat: reset with
// presence sampling, byte write and byte read, lsb first
// ----------------------------------------------------------------------------
//  channel  | handshake                    | payload
//  ---------+------------------------------+----------------------------------
//  input    | i_in_valid / o_in_stall      | i_in_data  (t_in_beat)
//  output   | o_out_valid / i_out_stall    | o_out_data (t_out_beat)
//  config   | i_cfg_we                     | i_cfg_idx, i_cfg_data
//
//  one input beat per cycle is taken and one result beat per cycle is given
//  while the output is not stalled; a beat goes to a queue slot, then the
//  engine step writes its result register; each step is a whole microsecond
//  tick, so the result register draining sets the rate of one beat per cycle
//  reset (synchronous, active low) empties the queue, idles the engine and
//  restores the timing registers to their defaults
//  a stall on the output holds the engine; the four-entry queue keeps taking
//  input beats until it fills, and only then is o_in_stall raised
// ----------------------------------------------------------------------------
module one_wire_bus_master #(
    parameter int TIMER_BITS = owbm_pkg::TIMER_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input beats, one per microsecond of bus time
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  owbm_pkg::t_in_beat              i_in_data,
    // result beats, one per input beat
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output owbm_pkg::t_out_beat             o_out_data,
    // timing register writes
    input  logic                            i_cfg_we,
    input  logic [owbm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  owbm_pkg::t_cfg_word             i_cfg_data
);

    logic            w_q_valid;
    logic            w_q_pop;
    owbm_pkg::t_qent w_q_ent;

    // front: tags command ticks and buffers all beats
    owbm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_data    (i_in_data),
        .o_q_valid (w_q_valid),
        .o_q_ent   (w_q_ent),
        .i_q_pop   (w_q_pop)
    );

    // back: phase sequencer, slot timer, shifter and result register
    owbm_back #(
        .TIMER_BITS (TIMER_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_q_ent    (w_q_ent),
        .o_q_pop    (w_q_pop),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_data     (o_out_data)
    );

endmodule
